// ===== rtl/hcpg_pkg.sv =====
// shared constants and tables for the helix circle point generator
`default_nettype none

package hcpg_pkg;

   localparam int MAX_SAMPLES  = 4096;
   localparam int PHASE_BITS   = 16;
   localparam int IDX_W        = 12;
   localparam int CNT_W        = 13;
   localparam int CURL_W       = 8;
   localparam int THICK_W      = 14;
   localparam int PT_W         = 16;
   localparam int DEN_W        = 12;
   localparam int NUM_W        = IDX_W + PHASE_BITS + 1;
   localparam int DIV_STEPS    = NUM_W;
   localparam int CORDIC_STEPS = 24;
   localparam int ANG_W        = 32;
   localparam int CW           = 33;
   localparam int OUT_SHIFT    = 16;
   localparam int FRAC_Q       = 14;
   localparam int MIX_W        = 32;
   localparam int E_W          = 18;
   localparam int PROD_W       = 35;

   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int MIX_LAT      = 2;
   localparam int PIPE_LAT     = DIV_STEPS + 1 + CORDIC_LAT + MIX_LAT;
   localparam int INV_TAP      = DIV_STEPS + CORDIC_LAT;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_NPOINTS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS = 2'd2;

   localparam logic [CNT_W-1:0]   NPOINTS_RST   = 13'd300;
   localparam logic [CURL_W-1:0]  TURNS_RST     = 8'd5;
   localparam logic [THICK_W-1:0] THICKNESS_RST = 14'd1638;

   localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

   // atan(2^-i) in 2^-32 turn
   localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81
   };

endpackage

`default_nettype wire

// ===== rtl/hcpg_req_if.sv =====
// request channel: sample index and coil select
`default_nettype none

interface hcpg_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcpg_pkg::IDX_W-1:0]    sample_index;
   logic                          coil_select;

   modport source (output valid, output sample_index, output coil_select, input ready);
   modport sink   (input valid, input sample_index, input coil_select, output ready);
endinterface

`default_nettype wire

// ===== rtl/hcpg_rsp_if.sv =====
// response channel: one 3d point
`default_nettype none

interface hcpg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [hcpg_pkg::PT_W-1:0]   point_x;
   logic signed [hcpg_pkg::PT_W-1:0]   point_y;
   logic signed [hcpg_pkg::PT_W-1:0]   point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/hcpg_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, keeps the low phase bits
`default_nettype none

module hcpg_divider (
   input  wire logic                              clock,
   input  wire logic                              adv,
   input  wire logic [hcpg_pkg::NUM_W-1:0]        num,
   input  wire logic [hcpg_pkg::DEN_W:0]          den2,
   output logic      [hcpg_pkg::PHASE_BITS-1:0]   quot
);
   import hcpg_pkg::*;

   logic [DEN_W:0]        rem_ff [DIV_STEPS];
   logic [NUM_W-1:0]      num_ff [DIV_STEPS];
   logic [PHASE_BITS-1:0] q_ff   [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_W:0]        rem_pv;
      logic [NUM_W-1:0]      num_pv;
      logic [PHASE_BITS-1:0] q_pv;
      logic [DEN_W+1:0]      trial;
      logic                  ge;
      logic [DEN_W:0]        rem_in;

      if (k == 0) begin : g_first
         assign rem_pv = '0;
         assign num_pv = num;
         assign q_pv   = '0;
      end else begin : g_next
         assign rem_pv = rem_ff[k-1];
         assign num_pv = num_ff[k-1];
         assign q_pv   = q_ff[k-1];
      end

      always_comb begin
         trial  = {rem_pv, num_pv[NUM_W-1]};
         ge     = trial >= {1'b0, den2};
         rem_in = ge ? (DEN_W+1)'(trial - {1'b0, den2}) : (DEN_W+1)'(trial);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_pv[NUM_W-2:0], 1'b0};
            q_ff[k]   <= {q_pv[PHASE_BITS-2:0], ge};
         end
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/hcpg_cordic.sv =====
// pipelined rotation cordic, one iteration per stage, gives sine and cosine in q1.14
`default_nettype none

module hcpg_cordic (
   input  wire logic                                   clock,
   input  wire logic                                   adv,
   input  wire logic        [hcpg_pkg::PHASE_BITS-1:0] phase,
   output logic signed      [hcpg_pkg::PT_W-1:0]       sin_q,
   output logic signed      [hcpg_pkg::PT_W-1:0]       cos_q
);
   import hcpg_pkg::*;

   localparam logic signed [CW-1:0] HALF = 33'sd32768;

   logic [ANG_W-1:0]       ang;
   logic                   flip;
   logic [ANG_W-1:0]       ang_f;
   logic signed [CW-1:0]   z0;

   logic signed [CW-1:0]   x_ff [CORDIC_STEPS];
   logic signed [CW-1:0]   y_ff [CORDIC_STEPS];
   logic signed [CW-1:0]   z_ff [CORDIC_STEPS];
   logic                   flip_ff [CORDIC_STEPS];

   logic signed [CW-1:0]   xo;
   logic signed [CW-1:0]   yo;
   logic signed [CW-1:0]   xr;
   logic signed [CW-1:0]   yr;
   logic signed [PT_W-1:0] sin_ff;
   logic signed [PT_W-1:0] cos_ff;

   always_comb begin
      ang   = {phase, (ANG_W-PHASE_BITS)'(0)};
      flip  = ang[ANG_W-1] ^ ang[ANG_W-2];
      ang_f = {ang[ANG_W-1] ^ flip, ang[ANG_W-2:0]};
      z0    = CW'(signed'(ang_f));
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CW-1:0] x_pv;
      logic signed [CW-1:0] y_pv;
      logic signed [CW-1:0] z_pv;
      logic                 f_pv;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      if (i == 0) begin : g_first
         assign x_pv = CORDIC_X0;
         assign y_pv = '0;
         assign z_pv = z0;
         assign f_pv = flip;
      end else begin : g_next
         assign x_pv = x_ff[i-1];
         assign y_pv = y_ff[i-1];
         assign z_pv = z_ff[i-1];
         assign f_pv = flip_ff[i-1];
      end

      assign dx = y_pv >>> i;
      assign dy = x_pv >>> i;

      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i] <= f_pv;
            if (!z_pv[CW-1]) begin
               x_ff[i] <= x_pv - dx;
               y_ff[i] <= y_pv + dy;
               z_ff[i] <= z_pv - ATAN_TURNS[i];
            end else begin
               x_ff[i] <= x_pv + dx;
               y_ff[i] <= y_pv - dy;
               z_ff[i] <= z_pv + ATAN_TURNS[i];
            end
         end
      end
   end

   always_comb begin
      xo = flip_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];
      yo = flip_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1];
      xr = (xo + HALF) >>> OUT_SHIFT;
      yr = (yo + HALF) >>> OUT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= PT_W'(xr);
         sin_ff <= PT_W'(yr);
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

`default_nettype wire

// ===== rtl/hcpg_mix.sv =====
// helix offset and radius scaling with rounding, saturation of x and y, two stages
`default_nettype none

module hcpg_mix (
   input  wire logic                                clock,
   input  wire logic                                adv,
   input  wire logic signed [hcpg_pkg::PT_W-1:0]    sin_a,
   input  wire logic signed [hcpg_pkg::PT_W-1:0]    cos_a,
   input  wire logic signed [hcpg_pkg::PT_W-1:0]    sin_c,
   input  wire logic signed [hcpg_pkg::PT_W-1:0]    cos_c,
   input  wire logic                                inv,
   input  wire logic        [hcpg_pkg::THICK_W-1:0] thickness,
   output logic signed      [hcpg_pkg::PT_W-1:0]    point_x,
   output logic signed      [hcpg_pkg::PT_W-1:0]    point_y,
   output logic signed      [hcpg_pkg::PT_W-1:0]    point_z
);
   import hcpg_pkg::*;

   localparam logic signed [MIX_W-1:0]  HALF_A = 32'sd8192;
   localparam logic signed [PROD_W-1:0] HALF_B = 35'sd8192;
   localparam logic signed [E_W-1:0]    ONE_Q  = 18'sd16384;
   localparam logic signed [PROD_W-1:0] SAT_HI = 35'sd32767;
   localparam logic signed [PROD_W-1:0] SAT_LO = -35'sd32768;

   logic signed [MIX_W-1:0]  t_s;
   logic signed [MIX_W-1:0]  pe;
   logic signed [MIX_W-1:0]  pz;
   logic signed [MIX_W-1:0]  pe_n;
   logic signed [MIX_W-1:0]  pz_n;
   logic signed [MIX_W-1:0]  pe_r;
   logic signed [MIX_W-1:0]  pz_r;

   logic signed [E_W-1:0]    e_ff;
   logic signed [PT_W-1:0]   s_ff;
   logic signed [PT_W-1:0]   c_ff;
   logic signed [PT_W-1:0]   z_ff;

   logic signed [E_W-1:0]    r;
   logic signed [PROD_W-1:0] px;
   logic signed [PROD_W-1:0] py;
   logic signed [PROD_W-1:0] xr;
   logic signed [PROD_W-1:0] yr;
   logic signed [PT_W-1:0]   x_in;
   logic signed [PT_W-1:0]   y_in;

   logic signed [PT_W-1:0]   x_ff;
   logic signed [PT_W-1:0]   y_ff;
   logic signed [PT_W-1:0]   zo_ff;

   always_comb begin
      t_s  = MIX_W'(signed'({1'b0, thickness}));
      pe   = MIX_W'(cos_c) * t_s;
      pz   = MIX_W'(sin_c) * t_s;
      pe_n = inv ? -pe : pe;
      pz_n = inv ? -pz : pz;
      pe_r = (pe_n + HALF_A) >>> FRAC_Q;
      pz_r = (pz_n + HALF_A) >>> FRAC_Q;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff <= E_W'(pe_r);
         z_ff <= PT_W'(pz_r);
         s_ff <= sin_a;
         c_ff <= cos_a;
      end
   end

   always_comb begin
      r  = ONE_Q + e_ff;
      px = PROD_W'(s_ff) * PROD_W'(r);
      py = PROD_W'(c_ff) * PROD_W'(r);
      xr = (px + HALF_B) >>> FRAC_Q;
      yr = (py + HALF_B) >>> FRAC_Q;
      if (xr > SAT_HI) begin
         x_in = PT_W'(SAT_HI);
      end else if (xr < SAT_LO) begin
         x_in = PT_W'(SAT_LO);
      end else begin
         x_in = PT_W'(xr);
      end
      if (yr > SAT_HI) begin
         y_in = PT_W'(SAT_HI);
      end else if (yr < SAT_LO) begin
         y_in = PT_W'(SAT_LO);
      end else begin
         y_in = PT_W'(yr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         zo_ff <= z_ff;
      end
   end

   assign point_x = x_ff;
   assign point_y = y_ff;
   assign point_z = zo_ff;

endmodule

`default_nettype wire

// ===== rtl/helix_circle_point_generator.sv =====
// top level: helix circle point generator pipeline
//
//   channel   dir   word
//   req_if    in    sample_index, coil_select
//   rsp_if    out   point_x, point_y, point_z
//   csr_*     in    point count, turn count, thickness writes
//
// one word per clock while the output word does not wait; 29 divider stages for the phase,
// one curl multiply, 25 cordic stages, two scaling stages
// the whole pipeline holds while the output word waits; valid bits travel with the data
// synchronous reset clears the valid bits and restores the register defaults
`default_nettype none

module helix_circle_point_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   hcpg_req_if.sink                                  req_if,
   hcpg_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_write,
   input  wire logic [hcpg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hcpg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import hcpg_pkg::*;

   logic [CNT_W-1:0]      count_ff;
   logic [CURL_W-1:0]     curl_ff;
   logic [THICK_W-1:0]    thick_ff;

   logic [PIPE_LAT-1:0]   vld_ff;
   logic [INV_TAP:0]      inv_ff;
   logic                  adv;

   logic [DEN_W-1:0]      den;
   logic [NUM_W-1:0]      num;
   logic [PHASE_BITS-1:0] quot;
   logic [PHASE_BITS-1:0] p_ff;
   logic [PHASE_BITS-1:0] cp_ff;

   logic signed [PT_W-1:0] sin_a;
   logic signed [PT_W-1:0] cos_a;
   logic signed [PT_W-1:0] sin_c;
   logic signed [PT_W-1:0] cos_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= NPOINTS_RST;
         curl_ff  <= TURNS_RST;
         thick_ff <= THICKNESS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NPOINTS:   count_ff <= CNT_W'(csr_wdata);
            CSR_TURNS:     curl_ff  <= CURL_W'(csr_wdata);
            CSR_THICKNESS: thick_ff <= THICK_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // clamp count to [2, MAX_SAMPLES], divisor is count - 1
   always_comb begin
      if (count_ff < CNT_W'(2)) begin
         den = DEN_W'(1);
      end else if (count_ff > CNT_W'(MAX_SAMPLES)) begin
         den = DEN_W'(MAX_SAMPLES - 1);
      end else begin
         den = DEN_W'(count_ff - CNT_W'(1));
      end
      num = {req_if.sample_index, (PHASE_BITS+1)'(0)} + NUM_W'(den);
   end

   assign adv          = !vld_ff[PIPE_LAT-1] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_if.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         inv_ff <= {inv_ff[INV_TAP-1:0], req_if.coil_select};
         p_ff   <= quot;
         cp_ff  <= PHASE_BITS'(quot * PHASE_BITS'(curl_ff));
      end
   end

   hcpg_divider u_div (
      .clock (clock),
      .adv   (adv),
      .num   (num),
      .den2  ({den, 1'b0}),
      .quot  (quot)
   );

   hcpg_cordic u_cordic_a (
      .clock (clock),
      .adv   (adv),
      .phase (p_ff),
      .sin_q (sin_a),
      .cos_q (cos_a)
   );

   hcpg_cordic u_cordic_c (
      .clock (clock),
      .adv   (adv),
      .phase (cp_ff),
      .sin_q (sin_c),
      .cos_q (cos_c)
   );

   hcpg_mix u_mix (
      .clock     (clock),
      .adv       (adv),
      .sin_a     (sin_a),
      .cos_a     (cos_a),
      .sin_c     (sin_c),
      .cos_c     (cos_c),
      .inv       (inv_ff[INV_TAP]),
      .thickness (thick_ff),
      .point_x   (rsp_if.point_x),
      .point_y   (rsp_if.point_y),
      .point_z   (rsp_if.point_z)
   );

   assign rsp_if.valid = vld_ff[PIPE_LAT-1];

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("output valid after reset");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !adv) |=> vld_ff[0])
      else $error("word lost in stalled pipeline");

   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.point_z <= 16'sd16384 && rsp_if.point_z >= -16'sd16384))
      else $error("point_z out of range");
`endif

endmodule

`default_nettype wire
